@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

@@ rtl/zcdp_pkg.sv @@
package zcdp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RK_NAME  = 2'd0,
    RK_ENTRY = 2'd1,
    RK_ERROR = 2'd2
  } rk_t;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // register select, bit 2 of the byte address
  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [15:0] TOTAL_RESET = 16'd0;
  localparam logic [15:0] LIMIT_RESET = 16'd64;

  localparam logic [31:0] CD_SIGNATURE = 32'h0201_4b50;
  localparam int          HEADER_BYTES = 46;
  localparam int          NAME_LIMIT   = 255;

  // header byte offsets
  localparam logic [5:0] HB_METHOD_LO = 6'd10;
  localparam logic [5:0] HB_METHOD_HI = 6'd11;
  localparam logic [5:0] HB_CSIZE_LO  = 6'd20;
  localparam logic [5:0] HB_CSIZE_HI  = 6'd23;
  localparam logic [5:0] HB_USIZE_LO  = 6'd24;
  localparam logic [5:0] HB_USIZE_HI  = 6'd27;
  localparam logic [5:0] HB_NLEN_LO   = 6'd28;
  localparam logic [5:0] HB_NLEN_HI   = 6'd29;
  localparam logic [5:0] HB_XLEN_LO   = 6'd30;
  localparam logic [5:0] HB_XLEN_HI   = 6'd31;
  localparam logic [5:0] HB_CLEN_LO   = 6'd32;
  localparam logic [5:0] HB_CLEN_HI   = 6'd33;
  localparam logic [5:0] HB_OFFS_LO   = 6'd42;
  localparam logic [5:0] HB_OFFS_HI   = 6'd45;
  localparam logic [5:0] HB_LAST      = 6'(HEADER_BYTES - 1);

  typedef struct packed {
    logic [15:0] total;
    logic [15:0] limit;
  } cfg_t;

  typedef struct packed {
    rk_t         kind;
    logic [15:0] index;
    logic [7:0]  nbyte;
    logic [7:0]  npos;
    logic [15:0] method;
    logic [31:0] csize;
    logic [31:0] usize;
    logic [31:0] offset;
    logic [7:0]  nlen;
    logic        last;
  } res_t;

endpackage

@@ rtl/zcdp_regs.sv @@
module zcdp_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output zcdp_pkg::cfg_t    cfg
);
  import zcdp_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total <= TOTAL_RESET;
      cfg.limit <= LIMIT_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_TOTAL: cfg.total <= pwdata[15:0];
        REG_LIMIT: cfg.limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL: prdata = {16'd0, cfg.total};
      REG_LIMIT: prdata = {16'd0, cfg.limit};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/zcdp_core.sv @@
module zcdp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              restart,
  input  logic [7:0]        data_byte,
  input  zcdp_pkg::cfg_t    cfg,
  output logic              res_fire,
  output zcdp_pkg::res_t    res
);
  import zcdp_pkg::*;

  phase_t      phase, phase_next;
  logic [16:0] byte_count, byte_count_next;
  logic [15:0] entries_done, entries_done_next;
  logic [31:0] signature_word, signature_word_next;
  logic [15:0] method_word, method_word_next;
  logic [31:0] compressed_word, compressed_word_next;
  logic [31:0] uncompressed_word, uncompressed_word_next;
  logic [15:0] stored_name_length, stored_name_length_next;
  logic [16:0] skip_length, skip_length_next;
  logic [31:0] offset_word, offset_word_next;

  // header field capture, applied only while in the header phase
  logic [5:0]  hdr_i;
  logic [1:0]  offs_lane;
  logic [31:0] sig_h;
  logic [15:0] meth_h;
  logic [31:0] csize_h;
  logic [31:0] usize_h;
  logic [15:0] nlen_h;
  logic [16:0] skip_h;
  logic [31:0] offs_h;

  logic [7:0]  kept_len;
  logic [16:0] pos_next;
  logic        name_kept;
  logic        name_end;
  logic [16:0] skip_dec;
  logic [16:0] ent_inc;
  logic        is_last;

  logic do_name, do_entry, do_error, to_name, to_skip, merged;

  assign hdr_i     = byte_count[5:0];
  assign offs_lane = hdr_i[1:0] - 2'd2;

  always_comb begin
    sig_h   = signature_word;
    meth_h  = method_word;
    csize_h = compressed_word;
    usize_h = uncompressed_word;
    nlen_h  = stored_name_length;
    skip_h  = skip_length;
    offs_h  = offset_word;
    case (hdr_i) inside
      [6'd0:6'd3]:                sig_h[{hdr_i[1:0], 3'b000} +: 8] = data_byte;
      HB_METHOD_LO, HB_METHOD_HI: meth_h[{hdr_i[0], 3'b000} +: 8] = data_byte;
      [HB_CSIZE_LO:HB_CSIZE_HI]:  csize_h[{hdr_i[1:0], 3'b000} +: 8] = data_byte;
      [HB_USIZE_LO:HB_USIZE_HI]:  usize_h[{hdr_i[1:0], 3'b000} +: 8] = data_byte;
      HB_NLEN_LO, HB_NLEN_HI:     nlen_h[{hdr_i[0], 3'b000} +: 8] = data_byte;
      HB_XLEN_LO:                 skip_h = {9'd0, data_byte};
      HB_XLEN_HI:                 skip_h = skip_length | {1'b0, data_byte, 8'd0};
      HB_CLEN_LO:                 skip_h = skip_length + {9'd0, data_byte};
      HB_CLEN_HI:                 skip_h = skip_length + {1'b0, data_byte, 8'd0};
      [HB_OFFS_LO:HB_OFFS_HI]:    offs_h[{offs_lane, 3'b000} +: 8] = data_byte;
      default: ;
    endcase
  end

  assign kept_len  = (stored_name_length > 16'(NAME_LIMIT)) ? 8'(NAME_LIMIT)
                                                            : stored_name_length[7:0];
  assign pos_next  = byte_count + 17'd1;
  assign name_kept = byte_count < {9'd0, kept_len};
  assign name_end  = pos_next >= {1'b0, stored_name_length};
  assign skip_dec  = (skip_length == 17'd0) ? 17'd0 : skip_length - 17'd1;
  assign ent_inc   = {1'b0, entries_done} + 17'd1;
  assign is_last   = (ent_inc >= {1'b0, cfg.total}) || (ent_inc >= {1'b0, cfg.limit});

  // what this byte does to the record
  always_comb begin
    do_name  = 1'b0;
    do_entry = 1'b0;
    do_error = 1'b0;
    to_name  = 1'b0;
    to_skip  = 1'b0;
    merged   = 1'b0;
    if (step) begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_i == HB_LAST) begin
            if (sig_h != CD_SIGNATURE) do_error = 1'b1;
            else if (nlen_h != 16'd0) to_name = 1'b1;
            else if (skip_h != 17'd0) to_skip = 1'b1;
            else do_entry = 1'b1;
          end
        end
        PH_NAME: begin
          if (name_end && skip_length == 17'd0) begin
            do_entry = 1'b1;
            merged   = name_kept;
          end else begin
            do_name = name_kept;
            to_skip = name_end;
          end
        end
        PH_SKIP: do_entry = (skip_dec == 17'd0);
        PH_STOP: ;
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (restart) begin
      phase_next = (cfg.total == 16'd0 || cfg.limit == 16'd0) ? PH_STOP : PH_HEADER;
    end else if (do_error) begin
      phase_next = PH_STOP;
    end else if (do_entry) begin
      phase_next = is_last ? PH_STOP : PH_HEADER;
    end else if (to_name) begin
      phase_next = PH_NAME;
    end else if (to_skip) begin
      phase_next = PH_SKIP;
    end
  end

  // datapath and result
  always_comb begin
    byte_count_next         = byte_count;
    entries_done_next       = entries_done;
    signature_word_next     = signature_word;
    method_word_next        = method_word;
    compressed_word_next    = compressed_word;
    uncompressed_word_next  = uncompressed_word;
    stored_name_length_next = stored_name_length;
    skip_length_next        = skip_length;
    offset_word_next        = offset_word;

    if (restart) begin
      byte_count_next         = 17'd0;
      entries_done_next       = 16'd0;
      signature_word_next     = 32'd0;
      method_word_next        = 16'd0;
      compressed_word_next    = 32'd0;
      uncompressed_word_next  = 32'd0;
      stored_name_length_next = 16'd0;
      skip_length_next        = 17'd0;
      offset_word_next        = 32'd0;
    end else if (step) begin
      unique case (phase)
        PH_HEADER: begin
          signature_word_next     = sig_h;
          method_word_next        = meth_h;
          compressed_word_next    = csize_h;
          uncompressed_word_next  = usize_h;
          stored_name_length_next = nlen_h;
          skip_length_next        = skip_h;
          offset_word_next        = offs_h;
          byte_count_next         = (to_name || to_skip || do_entry) ? 17'd0 : pos_next;
        end
        PH_NAME:  byte_count_next  = pos_next;
        PH_SKIP:  skip_length_next = skip_dec;
        PH_STOP:  ;
        default:  ;
      endcase
      if (do_entry) begin
        entries_done_next = ent_inc[15:0];
        byte_count_next   = 17'd0;
      end
    end

    res_fire   = do_name || do_entry || do_error;
    res        = '0;
    res.index  = entries_done;
    if (do_error) begin
      res.kind = RK_ERROR;
    end else if (do_entry) begin
      res.kind   = RK_ENTRY;
      res.nbyte  = merged ? data_byte : 8'd0;
      res.npos   = merged ? byte_count[7:0] : 8'd0;
      res.method = method_word_next;
      res.csize  = compressed_word_next;
      res.usize  = uncompressed_word_next;
      res.offset = offset_word_next;
      res.nlen   = kept_len;
      res.last   = is_last;
    end else begin
      res.kind  = RK_NAME;
      res.nbyte = data_byte;
      res.npos  = byte_count[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_STOP;
      byte_count         <= 17'd0;
      entries_done       <= 16'd0;
      signature_word     <= 32'd0;
      method_word        <= 16'd0;
      compressed_word    <= 32'd0;
      uncompressed_word  <= 32'd0;
      stored_name_length <= 16'd0;
      skip_length        <= 17'd0;
      offset_word        <= 32'd0;
    end else begin
      phase              <= phase_next;
      byte_count         <= byte_count_next;
      entries_done       <= entries_done_next;
      signature_word     <= signature_word_next;
      method_word        <= method_word_next;
      compressed_word    <= compressed_word_next;
      uncompressed_word  <= uncompressed_word_next;
      stored_name_length <= stored_name_length_next;
      skip_length        <= skip_length_next;
      offset_word        <= offset_word_next;
    end
  end

endmodule

@@ rtl/zip_central_directory_parser_unit.sv @@
// channel   handshake                 payload
// in        in_valid / in_ready       kind, data_byte
// out       out_valid / out_ready     result_kind ... last_entry
// cfg       psel penable pwrite       paddr, pwdata, prdata (pready tied high)
//
// one directory byte or restart request per cycle while in_ready is high; a result
// appears in the cycle after the byte that causes it, from the single-pass record state update
// reset leaves the parser stopped (entry_total resets to 0) until entry_total
// is written and a restart follows
// in_ready drops only while a result waits in the output register
// and out_ready is low; no clearing pass, no memories
module zip_central_directory_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [15:0] entry_index,
  output logic [7:0]  name_byte,
  output logic [7:0]  name_position,
  output logic [15:0] method,
  output logic [31:0] compressed_size,
  output logic [31:0] uncompressed_size,
  output logic [31:0] local_offset,
  output logic [7:0]  name_length,
  output logic        last_entry,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import zcdp_pkg::*;
  `include "assert_macros.svh"

  cfg_t cfg;
  res_t core_res;
  res_t res;
  logic core_fire;
  logic accept;
  logic step;
  logic restart;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign step     = accept && (kind == KIND_DATA);
  assign restart  = accept && (kind == KIND_RESTART);

  zcdp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  zcdp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .restart   (restart),
    .data_byte (data_byte),
    .cfg       (cfg),
    .res_fire  (core_fire),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && core_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && core_fire) begin
      res <= core_res;
    end
  end

  assign result_kind       = res.kind;
  assign entry_index       = res.index;
  assign name_byte         = res.nbyte;
  assign name_position     = res.npos;
  assign method            = res.method;
  assign compressed_size   = res.csize;
  assign uncompressed_size = res.usize;
  assign local_offset      = res.offset;
  assign name_length       = res.nlen;
  assign last_entry        = res.last;

  `ASSERT_CLK(a_stall_blocks_input, clk, rst, out_valid && !out_ready |-> !in_ready, "input taken while result stalled")
  `ASSERT_CLK(a_restart_no_result, clk, rst, in_valid && in_ready && kind == KIND_RESTART |=> !out_valid, "restart produced a result")
  `ASSERT_NEVER(a_name_pos_range, clk, rst, out_valid && result_kind == RK_NAME && name_position == 8'd255, "name position past kept name")

endmodule
